### rtl/stereo_loopback_mixer_assert.svh
// assertion macros for the stereo loopback mixer
`ifndef STEREO_LOOPBACK_MIXER_ASSERT_SVH
`define STEREO_LOOPBACK_MIXER_ASSERT_SVH

`ifndef SYNTH

`define SLM_ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("slm: forbidden condition seen");

`define SLM_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("slm: implication failed");

`else

`define SLM_ASSERT_NEVER(lbl, cond)

`define SLM_ASSERT_IMPL(lbl, ante, cons)

`endif

`endif

### rtl/slm_pkg.sv
package slm_pkg;

  localparam int CAP_W       = 32;
  localparam int SAMPLE_W    = 24;
  localparam int GAIN_W      = 16;
  localparam int OUT_W       = 32;
  localparam int COUNT_W     = 32;
  localparam int SUMSQ_W     = 64;
  localparam int PROD_W      = SAMPLE_W + GAIN_W;
  localparam int SQ_W        = 2 * SAMPLE_W;
  localparam int SUM_W       = PROD_W + 2;
  localparam int BIAS_W      = 37;
  localparam int PLAY_SHIFT  = 12;
  localparam int LIM_SHIFT   = 35;
  localparam int RND_SHIFT   = 4;
  localparam int QUEUE_DEPTH = 4;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = GAIN_W;

  localparam logic [CFG_INDEX_W-1:0] REG_GAIN_CH1_L = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_GAIN_CH2_L = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_GAIN_CH1_R = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_GAIN_CH2_R = 3'd3;

  localparam logic [OUT_W-1:0] OUT_MAX = 32'h7fff_ffff;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] cap1;
    logic signed [SAMPLE_W-1:0] cap2;
    logic [SAMPLE_W-1:0]        mag1;
    logic [SAMPLE_W-1:0]        mag2;
    logic signed [SAMPLE_W-1:0] play_l;
    logic signed [SAMPLE_W-1:0] play_r;
  } item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

endpackage

### rtl/slm_front.sv
module slm_front (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic signed [slm_pkg::CAP_W-1:0]       cap_ch1,
  input  logic signed [slm_pkg::CAP_W-1:0]       cap_ch2,
  input  logic signed [slm_pkg::SAMPLE_W-1:0]    play_left,
  input  logic signed [slm_pkg::SAMPLE_W-1:0]    play_right,
  input  logic                                   q_full,
  output logic                                   push,
  output slm_pkg::item_t                         item
);

  logic                           held;
  logic                           take;
  logic                           bad;
  logic [slm_pkg::SAMPLE_W-1:0]   c1;
  logic [slm_pkg::SAMPLE_W-1:0]   c2;
  logic [slm_pkg::SAMPLE_W-1:0]   m1;
  logic [slm_pkg::SAMPLE_W-1:0]   m2;

  assign in_stall = held && q_full;
  assign push     = held && !q_full;
  assign take     = in_valid && !in_stall;

  assign bad = (cap_ch1[7:0] != 8'd0) || (cap_ch2[7:0] != 8'd0);
  assign c1  = cap_ch1[slm_pkg::CAP_W-1:8];
  assign c2  = cap_ch2[slm_pkg::CAP_W-1:8];
  assign m1  = c1[slm_pkg::SAMPLE_W-1] ? (~c1 + 1'b1) : c1;
  assign m2  = c2[slm_pkg::SAMPLE_W-1] ? (~c2 + 1'b1) : c2;

  // invalid frames are dropped here
  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (take) begin
      held <= !bad;
    end else if (push) begin
      held <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      item.cap1   <= c1;
      item.cap2   <= c2;
      item.mag1   <= m1;
      item.mag2   <= m2;
      item.play_l <= play_left;
      item.play_r <= play_right;
    end
  end

endmodule

### rtl/slm_queue.sv
module slm_queue #(
  parameter int DEPTH = slm_pkg::QUEUE_DEPTH
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  slm_pkg::item_t  push_item,
  input  logic            pop,
  output slm_pkg::item_t  head,
  output slm_pkg::qstat_t stat
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  slm_pkg::item_t     mem [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;

  assign head       = mem[rd_ptr];
  assign stat.full  = (count == CNT_W'(DEPTH));
  assign stat.empty = (count == '0);

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

### rtl/slm_back.sv
module slm_back (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic                                      cfg_we,
  input  logic [slm_pkg::CFG_INDEX_W-1:0]           cfg_index,
  input  logic [slm_pkg::CFG_DATA_W-1:0]            cfg_data,
  input  logic                                      q_empty,
  input  slm_pkg::item_t                            head,
  output logic                                      pop,
  output logic                                      out_valid,
  input  logic                                      out_stall,
  output logic signed [slm_pkg::OUT_W-1:0]          out_left,
  output logic signed [slm_pkg::OUT_W-1:0]          out_right,
  output logic signed [slm_pkg::SAMPLE_W-1:0]       capture_left,
  output logic signed [slm_pkg::SAMPLE_W-1:0]       capture_right,
  output logic [slm_pkg::COUNT_W-1:0]               frame_index,
  output logic [slm_pkg::SAMPLE_W-1:0]              peak_ch1,
  output logic [slm_pkg::SAMPLE_W-1:0]              peak_ch2,
  output logic [slm_pkg::SUMSQ_W-1:0]               sumsq_ch1,
  output logic [slm_pkg::SUMSQ_W-1:0]               sumsq_ch2
);

  localparam int SW = slm_pkg::SAMPLE_W;
  localparam int PW = slm_pkg::PROD_W;
  localparam int MW = slm_pkg::SUM_W;
  localparam int BW = slm_pkg::BIAS_W;
  localparam int QW = slm_pkg::SUMSQ_W;
  localparam int XW = slm_pkg::SQ_W;
  localparam int CW = slm_pkg::COUNT_W;
  localparam int OW = slm_pkg::OUT_W;

  localparam logic signed [MW-1:0] LIM = MW'(1) <<< slm_pkg::LIM_SHIFT;

  function automatic logic [BW-1:0] clamp_bias(input logic signed [MW-1:0] v);
    logic signed [MW-1:0] c;
    logic signed [MW-1:0] b;
    begin
      if (v > LIM) begin
        c = LIM;
      end else if (v < -LIM) begin
        c = -LIM;
      end else begin
        c = v;
      end
      b = c + LIM;
      clamp_bias = b[BW-1:0];
    end
  endfunction

  // half to even on the low nibble, full scale saturates
  function automatic logic [OW-1:0] round_out(input logic [BW-1:0] u);
    logic [BW-slm_pkg::RND_SHIFT-1:0] q;
    logic [slm_pkg::RND_SHIFT-1:0]    rem;
    logic                             inc;
    logic [BW-slm_pkg::RND_SHIFT-1:0] qr;
    begin
      q   = u[BW-1:slm_pkg::RND_SHIFT];
      rem = u[slm_pkg::RND_SHIFT-1:0];
      inc = (rem > 4'd8) || ((rem == 4'd8) && q[0]);
      qr  = q + inc;
      if (qr[OW]) begin
        round_out = slm_pkg::OUT_MAX;
      end else begin
        round_out = {~qr[OW-1], qr[OW-2:0]};
      end
    end
  endfunction

  function automatic logic [QW-1:0] sat_add(input logic [QW-1:0] a,
                                            input logic [XW-1:0] b);
    logic [QW:0] s;
    begin
      s = {1'b0, a} + (QW + 1)'(b);
      sat_add = s[QW] ? '1 : s[QW-1:0];
    end
  endfunction

  logic signed [slm_pkg::GAIN_W-1:0] g1l, g2l, g1r, g2r;

  logic          advance;
  logic [CW-1:0] frame_counter;
  logic [SW-1:0] peak1, peak2;
  logic [XW-1:0] psq1, psq2;
  logic [QW-1:0] sumsq1, sumsq2;
  logic [SW-1:0] peak1_next, peak2_next;
  logic [QW-1:0] sumsq1_next, sumsq2_next;

  logic                 s1_valid;
  logic signed [PW-1:0] s1_p1l, s1_p2l, s1_p1r, s1_p2r;
  logic signed [SW-1:0] s1_play_l, s1_play_r, s1_cap1, s1_cap2;
  logic [CW-1:0]        s1_frame;
  logic [SW-1:0]        s1_peak1, s1_peak2;
  logic [QW-1:0]        s1_sumsq1, s1_sumsq2;

  logic signed [MW-1:0] mix_l, mix_r;

  logic                 s2_valid;
  logic [BW-1:0]        s2_bias_l, s2_bias_r;
  logic signed [SW-1:0] s2_cap1, s2_cap2;
  logic [CW-1:0]        s2_frame;
  logic [SW-1:0]        s2_peak1, s2_peak2;
  logic [QW-1:0]        s2_sumsq1, s2_sumsq2;

  assign advance = !(out_valid && out_stall);
  assign pop     = advance && !q_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      g1l <= '0;
      g2l <= '0;
      g1r <= '0;
      g2r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        slm_pkg::REG_GAIN_CH1_L: g1l <= cfg_data;
        slm_pkg::REG_GAIN_CH2_L: g2l <= cfg_data;
        slm_pkg::REG_GAIN_CH1_R: g1r <= cfg_data;
        slm_pkg::REG_GAIN_CH2_R: g2r <= cfg_data;
        default: ;
      endcase
    end
  end

  // meter state, square sums take the peak from before this frame
  assign peak1_next  = (head.mag1 > peak1) ? head.mag1 : peak1;
  assign peak2_next  = (head.mag2 > peak2) ? head.mag2 : peak2;
  assign sumsq1_next = sat_add(sumsq1, psq1);
  assign sumsq2_next = sat_add(sumsq2, psq2);

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_counter <= '0;
      peak1         <= '0;
      peak2         <= '0;
      psq1          <= '0;
      psq2          <= '0;
      sumsq1        <= '0;
      sumsq2        <= '0;
    end else if (pop) begin
      frame_counter <= frame_counter + 1'b1;
      peak1         <= peak1_next;
      peak2         <= peak2_next;
      psq1          <= XW'(peak1_next) * XW'(peak1_next);
      psq2          <= XW'(peak2_next) * XW'(peak2_next);
      sumsq1        <= sumsq1_next;
      sumsq2        <= sumsq2_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (advance) begin
      s1_valid  <= pop;
      s2_valid  <= s1_valid;
      out_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_p1l    <= PW'(head.cap1) * PW'(g1l);
      s1_p2l    <= PW'(head.cap2) * PW'(g2l);
      s1_p1r    <= PW'(head.cap1) * PW'(g1r);
      s1_p2r    <= PW'(head.cap2) * PW'(g2r);
      s1_play_l <= head.play_l;
      s1_play_r <= head.play_r;
      s1_cap1   <= head.cap1;
      s1_cap2   <= head.cap2;
      s1_frame  <= frame_counter;
      s1_peak1  <= peak1_next;
      s1_peak2  <= peak2_next;
      s1_sumsq1 <= sumsq1_next;
      s1_sumsq2 <= sumsq2_next;
    end
  end

  assign mix_l = MW'(s1_p1l) + MW'(s1_p2l) + (MW'(s1_play_l) <<< slm_pkg::PLAY_SHIFT);
  assign mix_r = MW'(s1_p1r) + MW'(s1_p2r) + (MW'(s1_play_r) <<< slm_pkg::PLAY_SHIFT);

  always_ff @(posedge clk) begin
    if (advance) begin
      s2_bias_l <= clamp_bias(mix_l);
      s2_bias_r <= clamp_bias(mix_r);
      s2_cap1   <= s1_cap1;
      s2_cap2   <= s1_cap2;
      s2_frame  <= s1_frame;
      s2_peak1  <= s1_peak1;
      s2_peak2  <= s1_peak2;
      s2_sumsq1 <= s1_sumsq1;
      s2_sumsq2 <= s1_sumsq2;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_left      <= round_out(s2_bias_l);
      out_right     <= round_out(s2_bias_r);
      capture_left  <= s2_cap1;
      capture_right <= s2_cap2;
      frame_index   <= s2_frame;
      peak_ch1      <= s2_peak1;
      peak_ch2      <= s2_peak2;
      sumsq_ch1     <= s2_sumsq1;
      sumsq_ch2     <= s2_sumsq2;
    end
  end

endmodule

### rtl/stereo_loopback_mixer.sv
// Stereo loopback mixer: one stereo frame in, one mixed frame out.
// Input channel: in_valid/in_stall with cap_ch1, cap_ch2 (32-bit captured
// samples) and play_left, play_right (Q0.23 playback). Output channel:
// out_valid/out_stall with mixed samples, converted captures, frame index
// and the peak meter readings. A frame whose captured low byte is nonzero
// is dropped in the front stage and produces no output beat.
// Gains are written through cfg_we/cfg_index/cfg_data; the user must do so
// only while the block is idle, as the block does not enforce it. Indexes
// above the gain list are ignored. Throughput is one frame per cycle while
// out_stall does not hold the back pipeline. After the edge that takes the
// input beat, a frame passes the front register, the queue, the product
// stage, the clamp stage and the output register, which raises out_valid.
// The meter state loop (peak compare and square) sets that rate.
// Reset clears gains, frame counter, peaks and square sums and empties
// the queue. When out_stall and out_valid are both high the back pipeline
// holds; the queue keeps absorbing frames until full, then in_stall rises.
`include "stereo_loopback_mixer_assert.svh"

module stereo_loopback_mixer #(
  parameter int QUEUE_DEPTH = slm_pkg::QUEUE_DEPTH
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_we,
  input  logic [slm_pkg::CFG_INDEX_W-1:0]        cfg_index,
  input  logic [slm_pkg::CFG_DATA_W-1:0]         cfg_data,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic signed [slm_pkg::CAP_W-1:0]       cap_ch1,
  input  logic signed [slm_pkg::CAP_W-1:0]       cap_ch2,
  input  logic signed [slm_pkg::SAMPLE_W-1:0]    play_left,
  input  logic signed [slm_pkg::SAMPLE_W-1:0]    play_right,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic signed [slm_pkg::OUT_W-1:0]       out_left,
  output logic signed [slm_pkg::OUT_W-1:0]       out_right,
  output logic signed [slm_pkg::SAMPLE_W-1:0]    capture_left,
  output logic signed [slm_pkg::SAMPLE_W-1:0]    capture_right,
  output logic [slm_pkg::COUNT_W-1:0]            frame_index,
  output logic                                   sample_invalid,
  output logic [slm_pkg::SAMPLE_W-1:0]           peak_ch1,
  output logic [slm_pkg::SAMPLE_W-1:0]           peak_ch2,
  output logic [slm_pkg::SUMSQ_W-1:0]            sumsq_ch1,
  output logic [slm_pkg::SUMSQ_W-1:0]            sumsq_ch2
);

  logic            push;
  logic            pop;
  slm_pkg::item_t  front_item;
  slm_pkg::item_t  head;
  slm_pkg::qstat_t q_stat;

  // bad frames never reach the output
  assign sample_invalid = 1'b0;

  slm_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .cap_ch1    (cap_ch1),
    .cap_ch2    (cap_ch2),
    .play_left  (play_left),
    .play_right (play_right),
    .q_full     (q_stat.full),
    .push       (push),
    .item       (front_item)
  );

  slm_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (front_item),
    .pop       (pop),
    .head      (head),
    .stat      (q_stat)
  );

  slm_back u_back (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .q_empty       (q_stat.empty),
    .head          (head),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_left      (out_left),
    .out_right     (out_right),
    .capture_left  (capture_left),
    .capture_right (capture_right),
    .frame_index   (frame_index),
    .peak_ch1      (peak_ch1),
    .peak_ch2      (peak_ch2),
    .sumsq_ch1     (sumsq_ch1),
    .sumsq_ch2     (sumsq_ch2)
  );

  `SLM_ASSERT_NEVER(a_queue_no_overflow, push && q_stat.full)
  `SLM_ASSERT_NEVER(a_queue_no_underflow, pop && q_stat.empty)
  `SLM_ASSERT_IMPL(a_stall_needs_full_queue, in_stall, q_stat.full)
  `SLM_ASSERT_IMPL(a_out_stall_holds_back, out_valid && out_stall, !pop)

endmodule

### test/testbench.sv
`timescale 1ns / 100ps

module testbench;

  localparam logic [slm_pkg::CFG_INDEX_W-1:0] REG_UNUSED_FIRST = 3'd4;
  localparam logic [slm_pkg::CFG_INDEX_W-1:0] REG_UNUSED_LAST  = 3'd7;
  localparam int QUIET_LIMIT = 2000;
  localparam int HOLD_CYCLES = 90;

  typedef struct packed {
    logic [slm_pkg::CAP_W-1:0]    cap1;
    logic [slm_pkg::CAP_W-1:0]    cap2;
    logic [slm_pkg::SAMPLE_W-1:0] play_l;
    logic [slm_pkg::SAMPLE_W-1:0] play_r;
  } frame_t;

  typedef struct packed {
    logic [slm_pkg::OUT_W-1:0]    mix_l;
    logic [slm_pkg::OUT_W-1:0]    mix_r;
    logic [slm_pkg::SAMPLE_W-1:0] cap_l;
    logic [slm_pkg::SAMPLE_W-1:0] cap_r;
    logic [slm_pkg::COUNT_W-1:0]  frame_no;
    logic                         invalid;
    logic [slm_pkg::SAMPLE_W-1:0] peak1;
    logic [slm_pkg::SAMPLE_W-1:0] peak2;
    logic [slm_pkg::SUMSQ_W-1:0]  sumsq1;
    logic [slm_pkg::SUMSQ_W-1:0]  sumsq2;
  } mix_result_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [slm_pkg::CFG_INDEX_W-1:0] cfg_index;
  logic [slm_pkg::CFG_DATA_W-1:0] cfg_data;
  logic in_valid;
  logic in_stall;
  logic signed [slm_pkg::CAP_W-1:0] cap_ch1;
  logic signed [slm_pkg::CAP_W-1:0] cap_ch2;
  logic signed [slm_pkg::SAMPLE_W-1:0] play_left;
  logic signed [slm_pkg::SAMPLE_W-1:0] play_right;
  logic out_valid;
  logic out_stall;
  logic signed [slm_pkg::OUT_W-1:0] out_left;
  logic signed [slm_pkg::OUT_W-1:0] out_right;
  logic signed [slm_pkg::SAMPLE_W-1:0] capture_left;
  logic signed [slm_pkg::SAMPLE_W-1:0] capture_right;
  logic [slm_pkg::COUNT_W-1:0] frame_index;
  logic sample_invalid;
  logic [slm_pkg::SAMPLE_W-1:0] peak_ch1;
  logic [slm_pkg::SAMPLE_W-1:0] peak_ch2;
  logic [slm_pkg::SUMSQ_W-1:0] sumsq_ch1;
  logic [slm_pkg::SUMSQ_W-1:0] sumsq_ch2;

  stereo_loopback_mixer uut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .cap_ch1(cap_ch1),
    .cap_ch2(cap_ch2),
    .play_left(play_left),
    .play_right(play_right),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_left(out_left),
    .out_right(out_right),
    .capture_left(capture_left),
    .capture_right(capture_right),
    .frame_index(frame_index),
    .sample_invalid(sample_invalid),
    .peak_ch1(peak_ch1),
    .peak_ch2(peak_ch2),
    .sumsq_ch1(sumsq_ch1),
    .sumsq_ch2(sumsq_ch2)
  );

  // mixer state as the block should hold it
  logic [slm_pkg::GAIN_W-1:0] gain_reg [0:7];
  logic [slm_pkg::COUNT_W-1:0] model_frame_no;
  logic [slm_pkg::SAMPLE_W-1:0] peak_lvl1;
  logic [slm_pkg::SAMPLE_W-1:0] peak_lvl2;
  logic [slm_pkg::SUMSQ_W-1:0] sq_sum1;
  logic [slm_pkg::SUMSQ_W-1:0] sq_sum2;

  frame_t frames_q[$];
  mix_result_t mixed_q[$];
  frame_t cur_frame;
  int frames_queued;
  int frames_sent;
  int beats_out;
  int mismatches;
  int in_idle_pct;
  int out_stall_pct;
  int hold_left;
  int next_hold;
  int quiet_cycles;

  always #1 clk = ~clk;

  // clamp to +-1.0 in Q.35, scale to 32 bits, round half to even
  function automatic logic [slm_pkg::OUT_W-1:0] scale_mix(input longint acc);
    longint lim;
    longint clamped;
    longint r;
    logic [63:0] u;
    logic [63:0] q;
    lim = longint'(1) << 35;
    clamped = acc;
    if (clamped > lim) clamped = lim;
    if (clamped < -lim) clamped = -lim;
    u = clamped + lim;
    q = u >> 4;
    if (u[3:0] > 4'd8 || (u[3:0] == 4'd8 && q[0])) q = q + 64'd1;
    r = $signed(q) - (longint'(1) << 31);
    if (r > 64'sd2147483647) r = 64'sd2147483647;
    return r[slm_pkg::OUT_W-1:0];
  endfunction

  function automatic logic [slm_pkg::SUMSQ_W-1:0] add_square(
      input logic [slm_pkg::SUMSQ_W-1:0] acc, input logic [slm_pkg::SAMPLE_W-1:0] pk);
    logic [63:0] p;
    logic [64:0] t;
    p = {40'd0, pk};
    t = {1'b0, acc} + {1'b0, p * p};
    return t[64] ? {slm_pkg::SUMSQ_W{1'b1}} : t[slm_pkg::SUMSQ_W-1:0];
  endfunction

  task automatic mix_frame(input frame_t f);
    longint c1, c2, pl, pr, g1l, g2l, g1r, g2r, a1, a2;
    mix_result_t m;
    if (f.cap1[7:0] != 8'h00 || f.cap2[7:0] != 8'h00) return;
    c1 = longint'($signed(f.cap1[slm_pkg::CAP_W-1:8]));
    c2 = longint'($signed(f.cap2[slm_pkg::CAP_W-1:8]));
    pl = longint'($signed(f.play_l));
    pr = longint'($signed(f.play_r));
    g1l = longint'($signed(gain_reg[slm_pkg::REG_GAIN_CH1_L]));
    g2l = longint'($signed(gain_reg[slm_pkg::REG_GAIN_CH2_L]));
    g1r = longint'($signed(gain_reg[slm_pkg::REG_GAIN_CH1_R]));
    g2r = longint'($signed(gain_reg[slm_pkg::REG_GAIN_CH2_R]));
    sq_sum1 = add_square(sq_sum1, peak_lvl1);
    sq_sum2 = add_square(sq_sum2, peak_lvl2);
    a1 = (c1 < 0) ? -c1 : c1;
    a2 = (c2 < 0) ? -c2 : c2;
    if (a1[slm_pkg::SAMPLE_W-1:0] > peak_lvl1) peak_lvl1 = a1[slm_pkg::SAMPLE_W-1:0];
    if (a2[slm_pkg::SAMPLE_W-1:0] > peak_lvl2) peak_lvl2 = a2[slm_pkg::SAMPLE_W-1:0];
    m.mix_l = scale_mix(c1 * g1l + c2 * g2l + pl * 4096);
    m.mix_r = scale_mix(c1 * g1r + c2 * g2r + pr * 4096);
    m.cap_l = c1[slm_pkg::SAMPLE_W-1:0];
    m.cap_r = c2[slm_pkg::SAMPLE_W-1:0];
    m.frame_no = model_frame_no;
    m.invalid = 1'b0;
    m.peak1 = peak_lvl1;
    m.peak2 = peak_lvl2;
    m.sumsq1 = sq_sum1;
    m.sumsq2 = sq_sum2;
    mixed_q.insert(mixed_q.size(), m);
    model_frame_no = model_frame_no + 1'b1;
  endtask

  task automatic compare_field(input string label, input logic [63:0] want,
                               input logic [63:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch on %s: expected %h, got %h", label, want, got);
    end
  endtask

  // input side
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        mix_frame(cur_frame);
        frames_sent++;
      end
      if (!in_valid || !in_stall) begin
        if (frames_q.size() != 0 && $urandom_range(99) >= in_idle_pct) begin
          cur_frame = frames_q.pop_front();
          in_valid <= 1'b1;
          cap_ch1 <= cur_frame.cap1;
          cap_ch2 <= cur_frame.cap2;
          play_left <= cur_frame.play_l;
          play_right <= cur_frame.play_r;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // output side
  always @(posedge clk) begin
    mix_result_t want;
    if (!rst && out_valid && !out_stall) begin
      beats_out++;
      if (mixed_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected output beat, frame_index %h", frame_index);
      end else begin
        want = mixed_q.pop_front();
        compare_field("out_left", 64'(want.mix_l), 64'($unsigned(out_left)));
        compare_field("out_right", 64'(want.mix_r), 64'($unsigned(out_right)));
        compare_field("capture_left", 64'(want.cap_l), 64'($unsigned(capture_left)));
        compare_field("capture_right", 64'(want.cap_r), 64'($unsigned(capture_right)));
        compare_field("frame_index", 64'(want.frame_no), 64'(frame_index));
        compare_field("sample_invalid", 64'(want.invalid), 64'(sample_invalid));
        compare_field("peak_ch1", 64'(want.peak1), 64'(peak_ch1));
        compare_field("peak_ch2", 64'(want.peak2), 64'(peak_ch2));
        compare_field("sumsq_ch1", want.sumsq1, sumsq_ch1);
        compare_field("sumsq_ch2", want.sumsq2, sumsq_ch2);
      end
    end
    // long back-pressure so the queue fills and the input stalls
    if (beats_out >= next_hold) begin
      hold_left = HOLD_CYCLES;
      next_hold += 550;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < out_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("testbench: FAIL");
      $finish;
    end
  end

  function automatic frame_t mk(input logic [slm_pkg::CAP_W-1:0] c1,
                                input logic [slm_pkg::CAP_W-1:0] c2,
                                input logic [slm_pkg::SAMPLE_W-1:0] pl,
                                input logic [slm_pkg::SAMPLE_W-1:0] pr);
    frame_t f;
    f.cap1 = c1;
    f.cap2 = c2;
    f.play_l = pl;
    f.play_r = pr;
    return f;
  endfunction

  function automatic logic [slm_pkg::CAP_W-1:0] rand_cap();
    logic [slm_pkg::CAP_W-1:0] v;
    v = $urandom();
    case ($urandom_range(9))
      0: v = 32'h8000_0000;
      1: v = 32'h7fff_ff00;
      2: v = 32'hffff_ff00;
      3: v = 32'h0000_0100;
      4: v = 32'h0000_0000;
      default: v[7:0] = 8'h00;
    endcase
    return v;
  endfunction

  function automatic logic [slm_pkg::SAMPLE_W-1:0] rand_play();
    logic [slm_pkg::SAMPLE_W-1:0] v;
    v = 24'($urandom());
    case ($urandom_range(7))
      0: v = 24'h7fffff;
      1: v = 24'h800000;
      2: v = 24'h000000;
      default: ;
    endcase
    return v;
  endfunction

  function automatic frame_t rand_frame();
    frame_t f;
    f = mk(rand_cap(), rand_cap(), rand_play(), rand_play());
    // a few frames with a dirty low byte
    if ($urandom_range(99) < 8) begin
      case ($urandom_range(2))
        0: f.cap1[7:0] = 8'($urandom_range(255, 1));
        1: f.cap2[7:0] = 8'($urandom_range(255, 1));
        default: begin
          f.cap1[7:0] = 8'($urandom_range(255, 1));
          f.cap2[7:0] = 8'($urandom_range(255, 1));
        end
      endcase
    end
    return f;
  endfunction

  function automatic logic [slm_pkg::GAIN_W-1:0] rand_gain();
    logic [slm_pkg::GAIN_W-1:0] g;
    g = 16'($urandom_range(65535));
    case ($urandom_range(5))
      0: g = 16'h8000;
      1: g = 16'h7fff;
      2: g = 16'h1000;
      3: g = 16'h0000;
      default: ;
    endcase
    return g;
  endfunction

  task automatic push_frame(input frame_t f);
    frames_q.insert(frames_q.size(), f);
    frames_queued++;
  endtask

  task automatic write_reg(input logic [slm_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [slm_pkg::CFG_DATA_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    if (idx <= slm_pkg::REG_GAIN_CH2_R) gain_reg[idx] = val;
  endtask

  task automatic load_gains(input logic [slm_pkg::GAIN_W-1:0] g1l,
                            input logic [slm_pkg::GAIN_W-1:0] g2l,
                            input logic [slm_pkg::GAIN_W-1:0] g1r,
                            input logic [slm_pkg::GAIN_W-1:0] g2r);
    write_reg(slm_pkg::REG_GAIN_CH1_L, g1l);
    write_reg(slm_pkg::REG_GAIN_CH2_L, g2l);
    write_reg(slm_pkg::REG_GAIN_CH1_R, g1r);
    write_reg(slm_pkg::REG_GAIN_CH2_R, g2r);
    // writes past the gain list must not land anywhere
    write_reg(3'($urandom_range(REG_UNUSED_LAST, REG_UNUSED_FIRST)),
              16'($urandom_range(65535)));
    cfg_we <= 1'b0;
  endtask

  // wait until every queued frame is sent and every kept frame has come back, then idle
  task automatic settle();
    while (frames_sent != frames_queued || mixed_q.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic run_random(input int n);
    for (int i = 0; i < n; i++) push_frame(rand_frame());
    settle();
  endtask

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = slm_pkg::REG_GAIN_CH1_L;
    cfg_data = '0;
    in_valid = 1'b0;
    cap_ch1 = '0;
    cap_ch2 = '0;
    play_left = '0;
    play_right = '0;
    out_stall = 1'b0;
    gain_reg = '{default: '0};
    model_frame_no = '0;
    peak_lvl1 = '0;
    peak_lvl2 = '0;
    sq_sum1 = '0;
    sq_sum2 = '0;
    frames_queued = 0;
    frames_sent = 0;
    beats_out = 0;
    mismatches = 0;
    in_idle_pct = 37;
    out_stall_pct = 37;
    hold_left = 0;
    next_hold = 450;
    quiet_cycles = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // gains at reset value, extremes and dirty low bytes
    push_frame(mk(32'h0000_0000, 32'h0000_0000, 24'h000000, 24'h000000));
    push_frame(mk(32'h7fff_ff00, 32'h8000_0000, 24'h7fffff, 24'h800000));
    push_frame(mk(32'h8000_0000, 32'h7fff_ff00, 24'h800000, 24'h7fffff));
    push_frame(mk(32'h0000_0001, 32'h0000_0000, 24'h000001, 24'h000000));
    push_frame(mk(32'h0000_0000, 32'h0000_00ff, 24'h000000, 24'h000000));
    push_frame(mk(32'h1234_5680, 32'h8765_43a5, 24'h123456, 24'h876543));
    push_frame(mk(32'hffff_ff00, 32'h0000_0100, 24'hffffff, 24'h000001));
    settle();

    // minus one into left hits positive full scale
    load_gains(16'hf000, 16'h0000, 16'h1000, 16'h0000);
    push_frame(mk(32'h8000_0000, 32'h0000_0000, 24'h000000, 24'h000000));
    push_frame(mk(32'h8000_0000, 32'h7fff_ff00, 24'h7fffff, 24'h800000));
    push_frame(mk(32'h7fff_ff00, 32'h0000_0000, 24'h7fffff, 24'h7fffff));
    settle();

    load_gains(16'h7fff, 16'h8000, 16'h8000, 16'h7fff);
    push_frame(mk(32'h7fff_ff00, 32'h8000_0000, 24'h7fffff, 24'h800000));
    push_frame(mk(32'h8000_0000, 32'h7fff_ff00, 24'h800000, 24'h7fffff));
    push_frame(mk(32'h0000_0100, 32'hffff_ff00, 24'h000000, 24'h000000));
    settle();

    // tiny gains put ties on the rounding boundary
    load_gains(16'h0008, 16'h0008, 16'hfff8, 16'h0018);
    push_frame(mk(32'h0000_0100, 32'h0000_0000, 24'h000000, 24'h000000));
    push_frame(mk(32'h0000_0300, 32'h0000_0000, 24'h000000, 24'h000000));
    push_frame(mk(32'h0000_0100, 32'h0000_0100, 24'h000000, 24'h000000));
    push_frame(mk(32'hffff_fd00, 32'h0000_0000, 24'h000000, 24'h000000));
    push_frame(mk(32'h0000_0500, 32'h0000_0200, 24'h000000, 24'h000000));
    push_frame(mk(32'h0000_0100, 32'h0000_0100, 24'h000001, 24'h800000));
    push_frame(mk(32'h0000_0700, 32'h0000_0300, 24'h000000, 24'h000000));
    settle();

    load_gains(16'($urandom_range(65535)), 16'($urandom_range(65535)),
               16'($urandom_range(65535)), 16'($urandom_range(65535)));
    run_random(300);

    load_gains(rand_gain(), rand_gain(), rand_gain(), rand_gain());
    run_random(300);

    in_idle_pct = 0;
    out_stall_pct = 0;
    load_gains(rand_gain(), rand_gain(), rand_gain(), rand_gain());
    run_random(300);
    in_idle_pct = 37;
    out_stall_pct = 37;

    load_gains(rand_gain(), rand_gain(), rand_gain(), rand_gain());
    run_random(300);

    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
